// ===== hw/rtl/fbrld_pkg.sv =====
// Shared types and constants for the flag-byte run-length decoder.
package fbrld_pkg;

  localparam int unsigned CHUNKS_PER_GROUP = 8;
  localparam int unsigned GROUP_IDX_W      = $clog2(CHUNKS_PER_GROUP);
  localparam int unsigned SIZE_W           = 4;   // holds a chunk size of 0..8

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CFG_W      = 3;

  localparam logic [APB_ADDR_W-1:0] REG_CHUNK_BYTES_ADDR = 3'd0;
  localparam logic [CFG_W-1:0]      CHUNK_BYTES_RESET    = 3'd3;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 17;

  typedef enum logic [1:0] {
    PH_FLAG     = 2'd0,
    PH_CHUNK    = 2'd1,
    PH_COUNT_HI = 2'd2,
    PH_COUNT_LO = 2'd3
  } phase_t;

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] chunk_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               truncated;
  } result_t;

endpackage

// ===== hw/rtl/fbrld_apb.sv =====
// APB register block holding the chunk size setting.
module fbrld_apb
  import fbrld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_W-1:0]      chunk_bytes
);

  logic hit;

  assign hit    = (paddr == REG_CHUNK_BYTES_ADDR);
  assign pready = 1'b1;
  assign prdata = hit ? APB_DATA_W'(chunk_bytes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_BYTES_RESET;
    end else if (psel && penable && pwrite && hit) begin
      chunk_bytes <= pwdata[CFG_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/fbrld_parser.sv =====
// Stream parser: flag/chunk/count state and the run record for one byte.
module fbrld_parser
  import fbrld_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] chunk_bytes,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_stream,
  output result_t          res
);

  localparam int unsigned ACC_W = 8 * MAX_CHUNK_BYTES;
  localparam int unsigned BIC_W = $clog2(MAX_CHUNK_BYTES + 1);

  phase_t                 phase, phase_next;
  logic [7:0]             group_flags, group_flags_next;
  logic [GROUP_IDX_W-1:0] chunk_in_group, chunk_in_group_next;
  logic [BIC_W-1:0]       byte_in_chunk, byte_in_chunk_next;
  logic [ACC_W-1:0]       chunk_accumulator, chunk_accumulator_next;
  logic [7:0]             count_high_byte, count_high_byte_next;

  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] bic_inc;
  logic              chunk_done;
  logic              chunk_flag;
  logic              last_in_group;
  logic [ACC_W-1:0]  acc_merged;
  logic [63:0]       acc_wide;

  // 0 acts as 1, oversize clamps to the built width
  always_comb begin
    if (chunk_bytes == '0) begin
      eff_size = SIZE_W'(1);
    end else if (SIZE_W'(chunk_bytes) > SIZE_W'(MAX_CHUNK_BYTES)) begin
      eff_size = SIZE_W'(MAX_CHUNK_BYTES);
    end else begin
      eff_size = SIZE_W'(chunk_bytes);
    end
  end

  assign bic_inc       = SIZE_W'(byte_in_chunk) + SIZE_W'(1);
  assign chunk_done    = (bic_inc >= eff_size);
  assign chunk_flag    = group_flags[chunk_in_group];
  assign last_in_group = (chunk_in_group == GROUP_IDX_W'(CHUNKS_PER_GROUP - 1));

  // byte lane select by position within the chunk
  always_comb begin
    acc_merged = chunk_accumulator;
    for (int i = 0; i < MAX_CHUNK_BYTES; i++) begin
      if (byte_in_chunk == BIC_W'(i)) begin
        acc_merged[8*i +: 8] = chunk_accumulator[8*i +: 8] | data_byte;
      end
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (end_of_stream) begin
        phase_next = PH_FLAG;
      end else begin
        unique case (phase)
          PH_FLAG:     phase_next = PH_CHUNK;
          PH_CHUNK: begin
            if (chunk_done) begin
              if (chunk_flag)         phase_next = PH_COUNT_HI;
              else if (last_in_group) phase_next = PH_FLAG;
              else                    phase_next = PH_CHUNK;
            end
          end
          PH_COUNT_HI: phase_next = PH_COUNT_LO;
          PH_COUNT_LO: phase_next = last_in_group ? PH_FLAG : PH_CHUNK;
          default:     phase_next = PH_FLAG;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    group_flags_next       = group_flags;
    chunk_in_group_next    = chunk_in_group;
    byte_in_chunk_next     = byte_in_chunk;
    chunk_accumulator_next = chunk_accumulator;
    count_high_byte_next   = count_high_byte;
    acc_wide               = 64'(chunk_accumulator);
    res.emit               = 1'b0;
    res.repeat_count       = COUNT_W'(1);
    res.truncated          = 1'b0;

    unique case (phase)
      PH_FLAG: begin
        group_flags_next       = data_byte;
        chunk_in_group_next    = '0;
        byte_in_chunk_next     = '0;
        chunk_accumulator_next = '0;
      end
      PH_CHUNK: begin
        acc_wide = 64'(acc_merged);
        if (chunk_done) begin
          if (chunk_flag) begin
            chunk_accumulator_next = acc_merged;
            res.emit               = end_of_stream;
            res.truncated          = 1'b1;
          end else begin
            res.emit               = 1'b1;
            chunk_accumulator_next = '0;
            byte_in_chunk_next     = '0;
            chunk_in_group_next    = chunk_in_group + GROUP_IDX_W'(1);
          end
        end else begin
          chunk_accumulator_next = acc_merged;
          byte_in_chunk_next     = BIC_W'(bic_inc);
          res.emit               = end_of_stream;
          res.truncated          = 1'b1;
        end
      end
      PH_COUNT_HI: begin
        count_high_byte_next = data_byte;
        res.emit             = end_of_stream;
        res.truncated        = 1'b1;
      end
      PH_COUNT_LO: begin
        res.emit               = 1'b1;
        res.repeat_count       = {1'b0, count_high_byte, data_byte} + COUNT_W'(1);
        chunk_accumulator_next = '0;
        byte_in_chunk_next     = '0;
        chunk_in_group_next    = chunk_in_group + GROUP_IDX_W'(1);
      end
      default: ;
    endcase

    // end of stream drops everything back to the reset state
    if (end_of_stream) begin
      group_flags_next       = '0;
      chunk_in_group_next    = '0;
      byte_in_chunk_next     = '0;
      chunk_accumulator_next = '0;
      count_high_byte_next   = '0;
    end

    res.chunk_value = acc_wide[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FLAG;
      group_flags       <= '0;
      chunk_in_group    <= '0;
      byte_in_chunk     <= '0;
      chunk_accumulator <= '0;
      count_high_byte   <= '0;
    end else if (step) begin
      phase             <= phase_next;
      group_flags       <= group_flags_next;
      chunk_in_group    <= chunk_in_group_next;
      byte_in_chunk     <= byte_in_chunk_next;
      chunk_accumulator <= chunk_accumulator_next;
      count_high_byte   <= count_high_byte_next;
    end
  end

endmodule

// ===== hw/rtl/fbrld_out_stage.sv =====
// Result register for run records with valid/stall toward the consumer.
module fbrld_out_stage
  import fbrld_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  result_t            res,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [VALUE_W-1:0] chunk_value,
  output logic [COUNT_W-1:0] repeat_count,
  output logic               truncated
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chunk_value  <= res.chunk_value;
      repeat_count <= res.repeat_count;
      truncated    <= res.truncated;
    end
  end

endmodule

// ===== hw/rtl/flag_byte_run_length_decoder_core.sv =====
// Top level of the flag-byte run-length decoder.
//
// Input channel: one compressed byte per request (data_byte, end_of_stream),
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: one run record per finished chunk (chunk_value,
// repeat_count, truncated), handed over where out_valid is high and
// out_stall is low. Flag bytes give none; count-high only at stream end.
// Configuration: APB register 0 (byte address 0) holds chunk_bytes.
// Path: an accepted byte waits in the input register; the record it makes
// is written into the result register when that byte advances.
// Throughput: one byte per cycle unless in_stall is high, set by the
// single input register ahead of the parser; parse logic is one pass from
// that register to the result register.
// Stall: a held result blocks only a byte that would make a new record;
// bytes that make none still flow. in_stall rises at most with a full
// input register behind a stalled result.
// Reset (synchronous, rst high): both registers empty, parser waits for a
// flag byte, chunk_bytes returns to 3.
module flag_byte_run_length_decoder_core
  import fbrld_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_stream,
  // run records
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_W-1:0]    chunk_value,
  output logic [COUNT_W-1:0]    repeat_count,
  output logic                  truncated
);

  logic [CFG_W-1:0] chunk_bytes;
  logic             in_reg_valid;
  logic [7:0]       in_reg_byte;
  logic             in_reg_eos;
  logic             advance;
  logic             out_free;
  result_t          res;

  fbrld_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .chunk_bytes (chunk_bytes)
  );

  // the held byte moves on unless it makes a record that cannot be stored
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && (!res.emit || out_free);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= data_byte;
      in_reg_eos  <= end_of_stream;
    end
  end

  fbrld_parser #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .chunk_bytes   (chunk_bytes),
    .step          (advance),
    .data_byte     (in_reg_byte),
    .end_of_stream (in_reg_eos),
    .res           (res)
  );

  fbrld_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && res.emit),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .chunk_value  (chunk_value),
    .repeat_count (repeat_count),
    .truncated    (truncated)
  );

  // a record written into the result register is presented next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |=> out_valid)
    else $error("emitted record not presented");

  // a cut-off record always carries a run length of one
  a_trunc_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> repeat_count == COUNT_W'(1))
    else $error("truncated record with run length other than one");

  // a run length is never zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != '0)
    else $error("zero run length");

  // a stalled input byte is held only behind a stalled record
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && res.emit)
    else $error("input stalled without a blocked record");

endmodule
